### rtl/nla_pkg.sv
package nla_pkg;

  localparam int COORD_W = 24;
  localparam int TAG_W   = 16;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;

  // Difference of two coordinates, its square and the sum of two squares
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = SQ_W + 1;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } entry_t;

endpackage

### rtl/nla_if.sv
interface nla_req_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic [nla_pkg::SLOT_W-1:0]         slot;
  logic [nla_pkg::TAG_W-1:0]          landmark_tag;
  logic signed [nla_pkg::COORD_W-1:0] pos_x;
  logic signed [nla_pkg::COORD_W-1:0] pos_y;

  modport source (output valid, mode, slot, landmark_tag, pos_x, pos_y, input ready);
  modport sink   (input valid, mode, slot, landmark_tag, pos_x, pos_y, output ready);
endinterface

interface nla_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [nla_pkg::TAG_W-1:0]  matched_tag;
  logic [nla_pkg::SLOT_W-1:0] matched_slot;
  logic                       found;

  modport source (output valid, matched_tag, matched_slot, found, input ready);
  modport sink   (input valid, matched_tag, matched_slot, found, output ready);
endinterface

interface nla_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [nla_pkg::COUNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/nearest_landmark_association_core.sv
// Nearest-neighbor data association against a landmark table of TABLE_DEPTH entries
// (tag, x, y in signed Q15.8). A word on req with mode 0 stores one landmark at req.slot
// and gives no result; slots at or above TABLE_DEPTH are dropped. A word with mode 1 is an
// observation: the block walks slots 0 .. landmark_count-1 (capped at TABLE_DEPTH) through
// one pipelined distance unit (table read, subtract, square, sum and compare), one slot per
// cycle, and returns the tag and slot with the smallest squared distance; ties go to the
// lowest slot. An empty table answers with found = 0, tag 0, slot 0 without a scan. req is
// not ready while a query is in flight; a finished result waits in the output register
// without blocking the next word. landmark_count is to be written through cfg (always
// ready) only while the block is idle; the block itself does not enforce this.
// Table entries are not cleared at reset: search only slots that were written.
module nearest_landmark_association_core #(
  parameter int TABLE_DEPTH = 64
) (
  input logic       clk,
  input logic       rst,
  nla_req_if.sink   req,
  nla_rsp_if.source rsp,
  nla_cfg_if.sink   cfg
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;

  logic [nla_pkg::COUNT_W-1:0] landmark_count;

  // Landmark table, one read port feeding the distance pipeline
  nla_pkg::entry_t mem [TABLE_DEPTH];
  nla_pkg::entry_t rd_q;

  logic signed [nla_pkg::COORD_W-1:0] obs_x;
  logic signed [nla_pkg::COORD_W-1:0] obs_y;

  logic          issuing;
  logic [AW-1:0] issue_idx;
  logic [AW-1:0] last_idx;

  logic          p1_vld, p2_vld, p3_vld;
  logic [AW-1:0] p1_idx, p2_idx, p3_idx;
  logic [nla_pkg::TAG_W-1:0] p2_tag, p3_tag;

  logic signed [nla_pkg::DIFF_W-1:0] dx, dy;
  logic signed [nla_pkg::DIFF_W-1:0] dx_next, dy_next;
  logic signed [2*nla_pkg::DIFF_W-1:0] prod_x, prod_y;
  logic [nla_pkg::SQ_W-1:0] sq_x, sq_y;
  logic [nla_pkg::DIST_W-1:0] dist_sum;

  logic                      have;
  logic [nla_pkg::DIST_W-1:0] best_d;
  logic [AW-1:0]             best_idx;
  logic [nla_pkg::TAG_W-1:0] best_tag;

  logic req_fire, wr_fire, qry_fire, scan_empty, load_rsp, take_best;
  int   count_cap;

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  assign req_fire = req.valid && req.ready;
  assign wr_fire  = req_fire && !req.mode && (int'(req.slot) < TABLE_DEPTH);
  assign qry_fire = req_fire && req.mode;

  // Cap the search at the table depth
  assign count_cap = (int'(landmark_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(landmark_count);

  assign scan_empty = !issuing && !p1_vld && !p2_vld && !p3_vld;
  assign load_rsp   = (state == ST_DONE) && (!rsp.valid || rsp.ready);

  // Distance datapath: subtract, square (registered), sum and compare
  assign dx_next = $signed({rd_q.x[nla_pkg::COORD_W-1], rd_q.x}) -
                   $signed({obs_x[nla_pkg::COORD_W-1], obs_x});
  assign dy_next = $signed({rd_q.y[nla_pkg::COORD_W-1], rd_q.y}) -
                   $signed({obs_y[nla_pkg::COORD_W-1], obs_y});
  assign prod_x  = dx * dx;
  assign prod_y  = dy * dy;
  assign dist_sum  = {1'b0, sq_x} + {1'b0, sq_y};
  assign take_best = p3_vld && (!have || (dist_sum < best_d));

  always_ff @(posedge clk) begin
    if (rst) begin
      landmark_count <= '0;
    end else if (cfg.valid && cfg.ready) begin
      landmark_count <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[AW'(req.slot)] <= '{tag: req.landmark_tag, x: req.pos_x, y: req.pos_y};
    end
    if (issuing) begin
      rd_q <= mem[issue_idx];
    end
  end

  // Sequencer: idle, scan the table, hand the result to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      issuing <= 1'b0;
      p1_vld  <= 1'b0;
      p2_vld  <= 1'b0;
      p3_vld  <= 1'b0;
      have    <= 1'b0;
    end else begin
      p1_vld <= issuing;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      if (take_best) begin
        have <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (qry_fire) begin
            have <= 1'b0;
            if (count_cap == 0) begin
              state <= ST_DONE;
            end else begin
              state   <= ST_SCAN;
              issuing <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (issuing && (issue_idx == last_idx)) begin
            issuing <= 1'b0;
          end
          if (scan_empty) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_rsp) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (qry_fire) begin
      obs_x     <= req.pos_x;
      obs_y     <= req.pos_y;
      issue_idx <= '0;
      last_idx  <= AW'(count_cap - 1);
    end else if (issuing) begin
      issue_idx <= issue_idx + 1'b1;
    end
    p1_idx <= issue_idx;
    p2_idx <= p1_idx;
    p2_tag <= rd_q.tag;
    dx     <= dx_next;
    dy     <= dy_next;
    p3_idx <= p2_idx;
    p3_tag <= p2_tag;
    sq_x   <= nla_pkg::SQ_W'(prod_x);
    sq_y   <= nla_pkg::SQ_W'(prod_y);
    if (take_best) begin
      best_d   <= dist_sum;
      best_idx <= p3_idx;
      best_tag <= p3_tag;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_rsp) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.found        <= have;
      rsp.matched_tag  <= have ? best_tag : '0;
      rsp.matched_slot <= have ? nla_pkg::SLOT_W'(best_idx) : '0;
    end
  end

`ifndef ASSERT_OFF
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (p1_vld || p2_vld || p3_vld) |-> !req.ready)
    else $error("request accepted while the distance pipeline is busy");

  a_issue_in_scan: assert property (@(posedge clk) disable iff (rst)
    issuing |-> (state == ST_SCAN))
    else $error("table read issued outside a scan");

  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && have) |-> (best_idx <= last_idx))
    else $error("winning slot lies beyond the searched range");

  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> (rsp.matched_tag == '0 && rsp.matched_slot == '0))
    else $error("empty result carries a nonzero tag or slot");
`endif

endmodule
